[src/rgbls_pkg.sv]
// ----------------------------------------------------------------------------
// rgbls_pkg
// Shared types and constants of the RGB LED chain serialiser.
// ----------------------------------------------------------------------------
package rgbls_pkg;

  localparam int WORD_W       = 24;
  localparam int BITS_PER_LED = 24;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int OUTQ_DEPTH   = 3;

  localparam logic [7:0]  PERIOD_RST    = 8'd80;
  localparam logic [7:0]  ONE_HIGH_RST  = 8'd53;
  localparam logic [7:0]  ZERO_HIGH_RST = 8'd26;
  localparam logic [15:0] LATCH_RST     = 16'd3200;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_ABORT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_PERIOD    = 2'd0,
    REG_ONE_HIGH  = 2'd1,
    REG_ZERO_HIGH = 2'd2,
    REG_LATCH     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  period_cycles;
    logic [7:0]  one_high_cycles;
    logic [7:0]  zero_high_cycles;
    logic [15:0] latch_cycles;
  } cfg_t;

  typedef struct packed {
    logic       sending;
    logic       data_slot;
    logic [4:0] bit_pos;
    logic       lt_one;
    logic       lt_zero;
    logic       ready_res;
    logic       accepted;
    logic       ready_event;
  } slot_info_t;

  typedef struct packed {
    logic line_level;
    logic ready_res;
    logic sending;
    logic accepted;
    logic ready_event;
  } result_t;

endpackage

[src/rgbls_ram.sv]
// ----------------------------------------------------------------------------
// rgbls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rgbls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/rgbls_regs.sv]
// ----------------------------------------------------------------------------
// rgbls_regs
// APB configuration registers: slot timing and latch time.
// ----------------------------------------------------------------------------
module rgbls_regs
  import rgbls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_cycles    <= PERIOD_RST;
      cfg.one_high_cycles  <= ONE_HIGH_RST;
      cfg.zero_high_cycles <= ZERO_HIGH_RST;
      cfg.latch_cycles     <= LATCH_RST;
    end else if (wr) begin
      case (idx)
        REG_PERIOD:    cfg.period_cycles    <= pwdata[7:0];
        REG_ONE_HIGH:  cfg.one_high_cycles  <= pwdata[7:0];
        REG_ZERO_HIGH: cfg.zero_high_cycles <= pwdata[7:0];
        REG_LATCH:     cfg.latch_cycles     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD:    prdata = {24'd0, cfg.period_cycles};
      REG_ONE_HIGH:  prdata = {24'd0, cfg.one_high_cycles};
      REG_ZERO_HIGH: prdata = {24'd0, cfg.zero_high_cycles};
      REG_LATCH:     prdata = {16'd0, cfg.latch_cycles};
      default:       prdata = '0;
    endcase
  end

endmodule

[src/rgbls_core.sv]
// ----------------------------------------------------------------------------
// rgbls_core
// Frame state, slot timing, latch and wake counters, colour bank selection.
// ----------------------------------------------------------------------------
module rgbls_core
  import rgbls_pkg::*;
#(
  parameter int LED_COUNT = 4,
  localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic [1:0]        func,
  input  logic [1:0]        led_index,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [31:0]       wake_delay,
  output logic              ram_we,
  output logic [LED_W:0]    ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic [LED_W:0]    ram_raddr,
  output logic              s1_valid,
  output slot_info_t        s1_info
);

  typedef enum logic [1:0] {
    PH_READY,
    PH_SEND,
    PH_WAIT
  } phase_t;

  function automatic logic [LED_W-1:0] wrap_index(input logic [1:0] v);
    logic [8:0] t;
    t = {7'd0, v};
    for (int k = 0; k < 3; k++) begin
      if (t >= 9'(LED_COUNT)) begin
        t = t - 9'(LED_COUNT);
      end
    end
    return t[LED_W-1:0];
  endfunction

  phase_t               phase, phase_next;
  logic                 in_data, in_data_next;
  logic [4:0]           bit_pos, bit_pos_next;
  logic [LED_W-1:0]     led, led_next;
  logic [7:0]           slot_tick, slot_tick_next;
  logic [15:0]          latch_left, latch_left_next;
  logic [31:0]          wake_left, wake_left_next;
  logic [LED_COUNT-1:0] store_sel, store_sel_next;
  logic [LED_COUNT-1:0] frame_sel, frame_sel_next;

  func_t            fn;
  logic [LED_W-1:0] load_idx;
  logic             wbank;
  logic [31:0]      wake_dec;
  logic [8:0]       tick_inc;
  logic             acc_c;
  logic             evt_c;
  slot_info_t       info;

  assign fn       = func_t'(func);
  assign load_idx = wrap_index(led_index);
  assign wake_dec = (wake_left != 32'd0) ? wake_left - 32'd1 : wake_left;
  assign tick_inc = {1'b0, slot_tick} + 9'd1;
  assign wbank    = (phase == PH_SEND && store_sel[load_idx] == frame_sel[load_idx])
                    ? ~store_sel[load_idx] : store_sel[load_idx];

  always_comb begin
    phase_next      = phase;
    in_data_next    = in_data;
    bit_pos_next    = bit_pos;
    led_next        = led;
    slot_tick_next  = slot_tick;
    latch_left_next = latch_left;
    wake_left_next  = wake_left;
    store_sel_next  = store_sel;
    frame_sel_next  = frame_sel;
    acc_c           = 1'b0;
    evt_c           = 1'b0;
    ram_we          = 1'b0;
    if (accept) begin
      case (fn)
        FUNC_LOAD: begin
          ram_we                   = 1'b1;
          store_sel_next[load_idx] = wbank;
        end
        FUNC_START: begin
          if (phase == PH_READY) begin
            frame_sel_next = store_sel;
            phase_next     = PH_SEND;
            in_data_next   = 1'b0;
            bit_pos_next   = 5'd0;
            led_next       = '0;
            slot_tick_next = 8'd0;
            wake_left_next = wake_delay;
            acc_c          = 1'b1;
          end
        end
        FUNC_ABORT: begin
          wake_left_next = 32'd0;
          if (phase == PH_READY) begin
            acc_c = 1'b1;
          end else if (phase == PH_WAIT && latch_left == 16'd0) begin
            phase_next = PH_READY;
            acc_c      = 1'b1;
          end
        end
        default: begin
          wake_left_next = wake_dec;
          if (phase == PH_SEND) begin
            if (tick_inc >= {1'b0, cfg.period_cycles}) begin
              slot_tick_next = 8'd0;
              if (!in_data) begin
                in_data_next = 1'b1;
                bit_pos_next = 5'd0;
                led_next     = '0;
              end else if (bit_pos == 5'(BITS_PER_LED - 1)) begin
                if (led == LED_W'(LED_COUNT - 1)) begin
                  phase_next      = PH_WAIT;
                  in_data_next    = 1'b0;
                  latch_left_next = cfg.latch_cycles;
                end else begin
                  led_next     = led + LED_W'(1);
                  bit_pos_next = 5'd0;
                end
              end else begin
                bit_pos_next = bit_pos + 5'd1;
              end
            end else begin
              slot_tick_next = tick_inc[7:0];
            end
          end else if (phase == PH_WAIT) begin
            if (latch_left == 16'd0 && wake_dec == 32'd0) begin
              phase_next = PH_READY;
              evt_c      = 1'b1;
            end else if (latch_left != 16'd0) begin
              latch_left_next = latch_left - 16'd1;
            end
          end
        end
      endcase
    end
  end

  assign ram_waddr = {wbank, load_idx};
  assign ram_wdata = {green, red, blue};
  assign ram_raddr = {frame_sel_next[led_next], led_next};

  always_comb begin
    info.sending     = (phase_next == PH_SEND);
    info.data_slot   = in_data_next;
    info.bit_pos     = bit_pos_next;
    info.lt_one      = (slot_tick_next < cfg.one_high_cycles);
    info.lt_zero     = (slot_tick_next < cfg.zero_high_cycles);
    info.ready_res   = (phase_next == PH_READY);
    info.accepted    = acc_c;
    info.ready_event = evt_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_READY;
      in_data    <= 1'b0;
      bit_pos    <= 5'd0;
      led        <= '0;
      slot_tick  <= 8'd0;
      latch_left <= 16'd0;
      wake_left  <= 32'd0;
      store_sel  <= '0;
      frame_sel  <= '0;
      s1_valid   <= 1'b0;
    end else begin
      phase      <= phase_next;
      in_data    <= in_data_next;
      bit_pos    <= bit_pos_next;
      led        <= led_next;
      slot_tick  <= slot_tick_next;
      latch_left <= latch_left_next;
      wake_left  <= wake_left_next;
      store_sel  <= store_sel_next;
      frame_sel  <= frame_sel_next;
      s1_valid   <= accept;
    end
    s1_info <= info;
  end

endmodule

[src/rgbls_out.sv]
// ----------------------------------------------------------------------------
// rgbls_out
// Line level from the fetched colour word, and the result queue.
// ----------------------------------------------------------------------------
module rgbls_out
  import rgbls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s1_valid,
  input  slot_info_t        s1_info,
  input  logic [WORD_W-1:0] word,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           head
);

  localparam int PW = $clog2(OUTQ_DEPTH);

  result_t       q [OUTQ_DEPTH];
  logic [PW-1:0] rp, wp;
  logic [PW:0]   count;
  result_t       res;
  logic [4:0]    bsel;
  logic          pop;

  assign bsel = 5'(WORD_W - 1) - s1_info.bit_pos;

  always_comb begin
    res.line_level  = s1_info.sending & s1_info.data_slot &
                      (word[bsel] ? s1_info.lt_one : s1_info.lt_zero);
    res.ready_res   = s1_info.ready_res;
    res.sending     = s1_info.sending;
    res.accepted    = s1_info.accepted;
    res.ready_event = s1_info.ready_event;
  end

  assign out_valid = (count != '0);
  assign head      = q[rp];
  assign pop       = out_valid & out_ready;
  assign room      = (count + (PW+1)'(s1_valid)) < (PW+1)'(OUTQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else begin
      if (s1_valid) begin
        wp <= (wp == PW'(OUTQ_DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(OUTQ_DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      count <= count + (PW+1)'(s1_valid) - (PW+1)'(pop);
    end
    if (s1_valid) begin
      q[wp] <= res;
    end
  end

endmodule

[src/rgb_led_chain_serializer.sv]
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer
// One-wire addressable RGB LED transmitter, driven one tick per beat.
// ----------------------------------------------------------------------------
// One input beat is accepted per clock cycle while in_ready is high. Its result
// is produced in two steps: the first updates the frame state and addresses
// the colour memory, the second picks the bit from the registered read word.
// A three-entry result queue lets input run on while results wait; in_ready
// drops only when that queue and the beat in flight fill it. Colours live in
// a RAM of 2 << LED_W words in two banks, so a started frame keeps its
// colours while new loads go to the other bank.
module rgb_led_chain_serializer
  import rgbls_pkg::*;
#(
  parameter int LED_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [1:0]        led_index,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [31:0]       wake_delay,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              line_level,
  output logic              ready_res,
  output logic              sending,
  output logic              accepted,
  output logic              ready_event,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int RAM_DEPTH = 2 << LED_W;

  cfg_t              cfg;
  logic              accept;
  logic              ram_we;
  logic [LED_W:0]    ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [LED_W:0]    ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              s1_valid;
  slot_info_t        s1_info;
  logic              room;
  result_t           head;

  assign in_ready = room;
  assign accept   = in_valid & in_ready;

  assign line_level  = head.line_level;
  assign ready_res   = head.ready_res;
  assign sending     = head.sending;
  assign accepted    = head.accepted;
  assign ready_event = head.ready_event;

  rgbls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgbls_core #(
    .LED_COUNT (LED_COUNT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .func       (func),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .wake_delay (wake_delay),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .s1_valid   (s1_valid),
    .s1_info    (s1_info)
  );

  rgbls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rgbls_out u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_info   (s1_info),
    .word      (ram_rdata),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

endmodule

[src/rgbls_checker.sv]
// ----------------------------------------------------------------------------
// rgbls_checker
// Port-level checks of the LED chain serialiser, bound to the top level.
// ----------------------------------------------------------------------------
module rgbls_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic line_level,
  input logic ready_res,
  input logic sending,
  input logic accepted,
  input logic ready_event
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_level) && $stable(ready_res)
      && $stable(sending) && $stable(accepted) && $stable(ready_event))
    else $error("result beat changed while stalled");

  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ready_res && sending))
    else $error("ready and sending both set");

  a_line_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_level |-> sending)
    else $error("line high outside a frame");

  a_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && ready_event |-> ready_res && !accepted)
    else $error("ready event without ready state");

endmodule

bind rgb_led_chain_serializer rgbls_checker u_rgbls_checker (.*);
